FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on aclk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHM_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define CHM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/chm_pkg.sv
package chm_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] K_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] K_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] S_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] S_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] S_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] S_FULL  = 2'd3;

endpackage

FILE: rtl/chm_out_reg.sv
module chm_out_reg #(
    parameter int DW = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_i,
    input  logic [DW-1:0]                 data_i,
    input  logic [chm_pkg::STATUS_W-1:0]  user_i,
    output logic                          room_o,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [DW-1:0]                 m_tdata,
    output logic [chm_pkg::STATUS_W-1:0]  m_tuser
);
    import chm_pkg::*;

    logic                valid_reg;
    logic [DW-1:0]       data_reg;
    logic [STATUS_W-1:0] user_reg;

    assign room_o   = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_i) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            data_reg <= data_i;
            user_reg <= user_i;
        end
    end

endmodule

FILE: rtl/chained_hash_map_with_resize_core.sv
// Insert writes the node; a refused insert or an unused kind goes straight to the result.
// Lookup and remove read the bucket head and walk the chain node by node; remove then checks for a shrink.
// A resize clears the new_size buckets of the other bank, then rehashes each old bucket and each entry.
// One request at a time; the result register lets the next request in while it waits.
// aresetn is synchronous, active low; after it rises the init state clears bucket 0,
// then s_tready rises.
`include "assert_macros.svh"

module chained_hash_map_with_resize_core #(
    parameter int NODE_CAPACITY = 1024,
    parameter int KEY_WIDTH     = 32,
    parameter int VALUE_WIDTH   = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // key, value_in
    input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [chm_pkg::KIND_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // value_out, entry_count, table_size
    output logic [((VALUE_WIDTH+$clog2(NODE_CAPACITY+1)+$clog2(2*NODE_CAPACITY)+1+7)/8)*8-1:0]
        m_tdata,
    // status
    output logic [chm_pkg::STATUS_W-1:0] m_tuser
);
    import chm_pkg::*;

    localparam int NC        = NODE_CAPACITY;
    localparam int KW        = KEY_WIDTH;
    localparam int VW        = VALUE_WIDTH;
    localparam int TABLE_MAX = 2 * NC;
    localparam int PW        = $clog2(NC + 1);
    localparam int FW        = $clog2(NC);
    localparam int BW        = $clog2(TABLE_MAX);
    localparam int CW        = $clog2(NC + 1);
    localparam int SW        = $clog2(TABLE_MAX) + 1;
    localparam int OUT_DW    = ((VW + CW + SW + 7) / 8) * 8;

    localparam logic [PW-1:0] NIL     = PW'(NC);
    localparam logic [CW-1:0] NC_CW   = CW'(NC);
    localparam logic [FW-1:0] FL_TOP  = FW'(NC - 1);
    localparam logic [SW-1:0] SZ_MAX  = SW'(TABLE_MAX);

    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_INS     = 4'd2;
    localparam logic [3:0] ST_HEAD    = 4'd3;
    localparam logic [3:0] ST_WALK_RD = 4'd4;
    localparam logic [3:0] ST_WALK_CK = 4'd5;
    localparam logic [3:0] ST_SHRINK  = 4'd6;
    localparam logic [3:0] ST_CLR     = 4'd7;
    localparam logic [3:0] ST_RH_HRD  = 4'd8;
    localparam logic [3:0] ST_RH_HEAD = 4'd9;
    localparam logic [3:0] ST_RH_CHK  = 4'd10;
    localparam logic [3:0] ST_RH_NODE = 4'd11;
    localparam logic [3:0] ST_RH_PUSH = 4'd12;
    localparam logic [3:0] ST_DONE    = 4'd13;

    logic [PW-1:0] bucket_mem [2*TABLE_MAX];
    logic [KW-1:0] key_mem    [NC];
    logic [VW-1:0] val_mem    [NC];
    logic [PW-1:0] link_mem   [NC];
    logic [FW-1:0] fl_mem     [NC];

    logic [3:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [BW-1:0]       bkt_reg, bkt_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [PW-1:0]       prev_reg, prev_next;
    logic                prev_nil_reg, prev_nil_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       hwm_reg, hwm_next;
    logic [SW-1:0]       size_reg, size_next;
    logic                bank_reg, bank_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VW-1:0]       vout_reg, vout_next;
    logic [SW-1:0]       ri_reg, ri_next;
    logic [SW-1:0]       os_reg, os_next;
    logic [PW-1:0]       rnx_reg, rnx_next;

    logic [BW:0]   b_raddr, b_waddr;
    logic          b_we;
    logic [PW-1:0] b_wdata, b_rd;
    logic [FW-1:0] n_raddr, kv_waddr, l_waddr, fl_raddr, fl_waddr;
    logic          kv_we, l_we, fl_we;
    logic [PW-1:0] l_wdata;
    logic [FW-1:0] fl_wdata, fl_rd;
    logic [KW-1:0] key_rd;
    logic [VW-1:0] val_rd;
    logic [PW-1:0] link_rd;

    logic [KW-1:0]    s_key;
    logic [VW-1:0]    s_val;
    logic [KW+SW-1:0] s_key_ext, rd_key_ext;
    logic [SW-1:0]    size_mask;
    logic [BW-1:0]    s_bkt, rd_bkt;
    logic [CW-1:0]    cnt_inc, cnt_dec;
    logic [SW-1:0]    ri_inc;
    logic [FW-1:0]    new_node;
    logic             out_room, out_load;

    assign s_key      = s_tdata[KW-1:0];
    assign s_val      = s_tdata[KW+VW-1:KW];
    assign size_mask  = size_reg - SW'(1);
    assign s_key_ext  = {{SW{1'b0}}, s_key};
    assign rd_key_ext = {{SW{1'b0}}, key_rd};
    assign s_bkt      = BW'(s_key_ext[SW-1:0] & size_mask);
    assign rd_bkt     = BW'(rd_key_ext[SW-1:0] & size_mask);
    assign cnt_inc    = count_reg + CW'(1);
    assign cnt_dec    = count_reg - CW'(1);
    assign ri_inc     = ri_reg + SW'(1);
    assign new_node   = (count_reg < hwm_reg) ? fl_rd : count_reg[FW-1:0];
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_DONE) && out_room;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        bkt_next      = bkt_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_nil_next = prev_nil_reg;
        count_next    = count_reg;
        hwm_next      = hwm_reg;
        size_next     = size_reg;
        bank_next     = bank_reg;
        status_next   = status_reg;
        vout_next     = vout_reg;
        ri_next       = ri_reg;
        os_next       = os_reg;
        rnx_next      = rnx_reg;
        b_raddr       = {bank_reg, bkt_reg};
        b_we          = 1'b0;
        b_waddr       = {bank_reg, bkt_reg};
        b_wdata       = NIL;
        n_raddr       = cur_reg[FW-1:0];
        kv_we         = 1'b0;
        kv_waddr      = new_node;
        l_we          = 1'b0;
        l_waddr       = new_node;
        l_wdata       = b_rd;
        fl_raddr      = FL_TOP - count_reg[FW-1:0];
        fl_we         = 1'b0;
        fl_waddr      = FL_TOP - cnt_dec[FW-1:0];
        fl_wdata      = cur_reg[FW-1:0];

        case (state_reg)
            ST_INIT: begin
                b_we       = 1'b1;
                b_waddr    = '0;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                b_raddr = {bank_reg, s_bkt};
                if (s_tvalid) begin
                    kind_next     = s_tuser;
                    key_next      = s_key;
                    val_next      = s_val;
                    bkt_next      = s_bkt;
                    vout_next     = '0;
                    prev_nil_next = 1'b1;
                    case (s_tuser)
                        K_INSERT: begin
                            if (count_reg >= NC_CW) begin
                                status_next = S_FULL;
                                state_next  = ST_DONE;
                            end else begin
                                status_next = S_OK;
                                state_next  = ST_INS;
                            end
                        end
                        K_LOOKUP, K_REMOVE: begin
                            status_next = S_MISS;
                            state_next  = ST_HEAD;
                        end
                        default: begin
                            status_next = S_MISS;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                kv_we      = 1'b1;
                l_we       = 1'b1;
                b_we       = 1'b1;
                b_wdata    = PW'(new_node);
                count_next = cnt_inc;
                if (count_reg == hwm_reg) begin
                    hwm_next = cnt_inc;
                end
                if (SW'(cnt_inc) == size_reg && size_reg < SZ_MAX) begin
                    os_next    = size_reg;
                    size_next  = size_reg << 1;
                    ri_next    = '0;
                    state_next = ST_CLR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_HEAD: begin
                cur_next   = b_rd;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                if (cur_reg >= NIL) begin
                    state_next = (kind_reg == K_REMOVE) ? ST_SHRINK : ST_DONE;
                end else begin
                    state_next = ST_WALK_CK;
                end
            end
            ST_WALK_CK: begin
                if (key_rd == key_reg) begin
                    if (kind_reg == K_LOOKUP) begin
                        status_next = S_FOUND;
                        vout_next   = val_rd;
                        state_next  = ST_DONE;
                    end else begin
                        if (prev_nil_reg) begin
                            b_we    = 1'b1;
                            b_wdata = link_rd;
                        end else begin
                            l_we    = 1'b1;
                            l_waddr = prev_reg[FW-1:0];
                            l_wdata = link_rd;
                        end
                        fl_we       = 1'b1;
                        count_next  = cnt_dec;
                        status_next = S_OK;
                        state_next  = ST_SHRINK;
                    end
                end else begin
                    prev_next     = cur_reg;
                    prev_nil_next = 1'b0;
                    cur_next      = link_rd;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_SHRINK: begin
                if (count_reg != '0 && SW'(count_reg) < (size_reg >> 2)) begin
                    os_next    = size_reg;
                    size_next  = size_reg >> 1;
                    ri_next    = '0;
                    state_next = ST_CLR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CLR: begin
                b_we    = 1'b1;
                b_waddr = {!bank_reg, ri_reg[BW-1:0]};
                ri_next = ri_inc;
                if (ri_inc == size_reg) begin
                    ri_next    = '0;
                    state_next = ST_RH_HRD;
                end
            end
            ST_RH_HRD: begin
                b_raddr    = {bank_reg, ri_reg[BW-1:0]};
                state_next = ST_RH_HEAD;
            end
            ST_RH_HEAD: begin
                cur_next   = b_rd;
                state_next = ST_RH_CHK;
            end
            ST_RH_CHK: begin
                if (cur_reg >= NIL) begin
                    ri_next = ri_inc;
                    if (ri_inc == os_reg) begin
                        bank_next  = !bank_reg;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RH_HRD;
                    end
                end else begin
                    state_next = ST_RH_NODE;
                end
            end
            ST_RH_NODE: begin
                rnx_next   = link_rd;
                bkt_next   = rd_bkt;
                b_raddr    = {!bank_reg, rd_bkt};
                state_next = ST_RH_PUSH;
            end
            ST_RH_PUSH: begin
                l_we       = 1'b1;
                l_waddr    = cur_reg[FW-1:0];
                l_wdata    = b_rd;
                b_we       = 1'b1;
                b_waddr    = {!bank_reg, bkt_reg};
                b_wdata    = cur_reg;
                cur_next   = rnx_reg;
                state_next = ST_RH_CHK;
            end
            ST_DONE: begin
                if (out_room) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            count_reg <= '0;
            hwm_reg   <= '0;
            size_reg  <= SW'(1);
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            hwm_reg   <= hwm_next;
            size_reg  <= size_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_nil_reg <= prev_nil_next;
        status_reg   <= status_next;
        vout_reg     <= vout_next;
        ri_reg       <= ri_next;
        os_reg       <= os_next;
        rnx_reg      <= rnx_next;
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            bucket_mem[b_waddr] <= b_wdata;
        end
        b_rd <= bucket_mem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (kv_we) begin
            key_mem[kv_waddr] <= key_reg;
            val_mem[kv_waddr] <= val_reg;
        end
        key_rd <= key_mem[n_raddr];
        val_rd <= val_mem[n_raddr];
    end

    always_ff @(posedge aclk) begin
        if (l_we) begin
            link_mem[l_waddr] <= l_wdata;
        end
        link_rd <= link_mem[n_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fl_we) begin
            fl_mem[fl_waddr] <= fl_wdata;
        end
        fl_rd <= fl_mem[fl_raddr];
    end

    chm_out_reg #(
        .DW(OUT_DW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (out_load),
        .data_i   (OUT_DW'({size_reg, count_reg, vout_reg})),
        .user_i   (status_reg),
        .room_o   (out_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `CHM_ASSERT_NOW(a_size_pow2, $onehot(size_reg), "table size not a power of two")
    `CHM_ASSERT_NOW(a_hwm_bound, count_reg <= hwm_reg && hwm_reg <= NC_CW, "free list mark broken")
    `CHM_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != ST_IDLE, "accept not taken")
    `CHM_ASSERT_IMPL(a_rehash_bank, b_we && (state_reg == ST_CLR || state_reg == ST_RH_PUSH), b_waddr[BW] != bank_reg, "rehash writes live bank")

endmodule

FILE: sim/chained_hash_map_with_resize_core_tb.sv
module chained_hash_map_with_resize_core_tb;
    import chm_pkg::*;

    localparam int CAP = 1024;
    localparam int TMAX = 2 * CAP;
    localparam int NIL = CAP;
    localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 60000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [31:0]       key;
        logic [7:0]        value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          value;
        logic [10:0]         entries;
        logic [11:0]         buckets;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // key[31:0], value_in[39:32]
    logic [1:0]  s_tuser = K_INSERT; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // value_out[7:0], entry_count[18:8], table_size[30:19]
    logic [1:0]  m_tuser;           // status

    chained_hash_map_with_resize_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // map shadow
    int          bucket_head[TMAX];
    logic [31:0] node_key[CAP];
    logic [7:0]  node_val[CAP];
    int          node_next[CAP];
    int          free_stack[CAP];
    int          entry_cnt;
    int          bucket_cnt;

    request_t    pending_reqs[$];
    reply_t      expected_replies[$];
    logic [31:0] gen_keys[$];
    int          errors = 0;
    int          kind_seen[4];
    int          full_seen = 0;
    int          found_seen = 0;
    int          peak_buckets = 1;
    bit          s_fire = 0;
    int          s_gap = 0;
    int          m_gap = 0;
    bit          calm = 0;
    int          idle_cycles = 0;

    function automatic int bucket_of(logic [31:0] k);
        return int'(k & 32'(bucket_cnt - 1));
    endfunction

    function automatic void map_reset();
        for (int i = 0; i < TMAX; i++) bucket_head[i] = NIL;
        for (int i = 0; i < CAP; i++) begin
            node_key[i] = '0;
            node_val[i] = '0;
            node_next[i] = NIL;
            free_stack[i] = CAP - 1 - i;
        end
        entry_cnt = 0;
        bucket_cnt = 1;
    endfunction

    function automatic void rebuild_chains(int old_size);
        int fresh[TMAX];
        int j, nx, b;
        for (int i = 0; i < TMAX; i++) fresh[i] = NIL;
        for (int i = 0; i < old_size; i++) begin
            j = bucket_head[i];
            while (j < NIL) begin
                nx = node_next[j];
                b = bucket_of(node_key[j]);
                node_next[j] = fresh[b];
                fresh[b] = j;
                j = nx;
            end
        end
        for (int i = 0; i < TMAX; i++) bucket_head[i] = fresh[i];
    endfunction

    function automatic reply_t apply_request(request_t r);
        reply_t rep;
        int b, j, prev;
        rep = '{status: S_MISS, value: 8'd0, entries: 11'd0, buckets: 12'd0};
        b = bucket_of(r.key);
        case (r.kind)
            K_INSERT: begin
                if (entry_cnt >= CAP) begin
                    rep.status = S_FULL;
                end else begin
                    j = free_stack[CAP - 1 - entry_cnt];
                    node_key[j] = r.key;
                    node_val[j] = r.value;
                    node_next[j] = bucket_head[b];
                    bucket_head[b] = j;
                    entry_cnt++;
                    rep.status = S_OK;
                    if (entry_cnt == bucket_cnt && bucket_cnt < TMAX) begin
                        bucket_cnt *= 2;
                        rebuild_chains(bucket_cnt / 2);
                    end
                end
            end
            K_LOOKUP: begin
                j = bucket_head[b];
                while (j < NIL) begin
                    if (node_key[j] == r.key) begin
                        rep.status = S_FOUND;
                        rep.value = node_val[j];
                        break;
                    end
                    j = node_next[j];
                end
            end
            K_REMOVE: begin
                prev = NIL;
                j = bucket_head[b];
                while (j < NIL) begin
                    if (node_key[j] == r.key) begin
                        if (prev == NIL) bucket_head[b] = node_next[j];
                        else node_next[prev] = node_next[j];
                        if (entry_cnt > 0) begin
                            entry_cnt--;
                            free_stack[CAP - 1 - entry_cnt] = j;
                        end
                        rep.status = S_OK;
                        break;
                    end
                    prev = j;
                    j = node_next[j];
                end
                if (entry_cnt > 0 && entry_cnt < bucket_cnt / 4) begin
                    bucket_cnt /= 2;
                    rebuild_chains(bucket_cnt * 2);
                end
            end
            default: ;
        endcase
        rep.entries = 11'(entry_cnt);
        rep.buckets = 12'(bucket_cnt);
        return rep;
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic queue_req(logic [KIND_W-1:0] k, logic [31:0] key, logic [7:0] v);
        pending_reqs.push_back('{kind: k, key: key, value: v});
    endtask

    function automatic logic [31:0] fresh_key();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return $urandom();
        if (p < 9) return 32'($urandom_range(0, 4095));
        return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
    endfunction

    // pct_ins / pct_look / pct_rem percentages, rest unused kind and misses
    task automatic queue_random(int n, int pct_ins, int pct_look, int pct_rem);
        int p, idx;
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < pct_ins) begin
                if (gen_keys.size() > 0 && $urandom_range(0, 19) == 0)
                    k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
                else
                    k = fresh_key();
                gen_keys.push_back(k);
                queue_req(K_INSERT, k, 8'($urandom()));
            end else if (p < pct_ins + pct_look) begin
                if (gen_keys.size() > 0 && $urandom_range(0, 3) != 0)
                    k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
                else
                    k = fresh_key();
                queue_req(K_LOOKUP, k, 8'($urandom()));
            end else if (p < pct_ins + pct_look + pct_rem) begin
                if (gen_keys.size() > 0 && $urandom_range(0, 5) != 0) begin
                    idx = $urandom_range(0, gen_keys.size() - 1);
                    k = gen_keys[idx];
                    gen_keys.delete(idx);
                end else begin
                    k = fresh_key();
                end
                queue_req(K_REMOVE, k, 8'($urandom()));
            end else if (p < 98) begin
                queue_req(K_LOOKUP, fresh_key(), 8'($urandom()));
            end else begin
                queue_req(K_UNUSED, fresh_key(), 8'($urandom()));
            end
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                s_fire = 0;
                if ($urandom_range(0, 199) == 0) calm = !calm;
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    s_tdata <= {r.value, r.key};
                    s_tuser <= r.kind;
                    s_tvalid <= 1'b1;
                    s_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                m_gap = pick_gap();
            end
        end
    end

    // acceptance, prediction and monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                request_t r;
                r = '{kind: s_tuser, key: s_tdata[31:0], value: s_tdata[39:32]};
                expected_replies.push_back(apply_request(r));
                kind_seen[s_tuser]++;
                if (bucket_cnt > peak_buckets) peak_buckets = bucket_cnt;
                s_fire = 1;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected transfer, status", m_tuser, -1);
                end else begin
                    reply_t w;
                    w = expected_replies.pop_front();
                    if (m_tuser == S_FULL) full_seen++;
                    if (m_tuser == S_FOUND) found_seen++;
                    if (m_tuser !== w.status) report_mismatch("status", m_tuser, w.status);
                    if (m_tdata[7:0] !== w.value)
                        report_mismatch("value_out", m_tdata[7:0], w.value);
                    if (m_tdata[18:8] !== w.entries)
                        report_mismatch("entry_count", m_tdata[18:8], w.entries);
                    if (m_tdata[30:19] !== w.buckets)
                        report_mismatch("table_size", m_tdata[30:19], w.buckets);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        map_reset();
        // directed: empty map cases, extremes, duplicates, unused kind
        queue_req(K_LOOKUP, 32'd0, 8'd0);
        queue_req(K_REMOVE, 32'd5, 8'd0);
        queue_req(K_INSERT, 32'd0, 8'd0);
        queue_req(K_INSERT, 32'hFFFF_FFFF, 8'hFF);
        queue_req(K_INSERT, 32'hFFFF_FFFF, 8'h5A);
        queue_req(K_LOOKUP, 32'hFFFF_FFFF, 8'd0);
        queue_req(K_LOOKUP, 32'd0, 8'hFF);
        queue_req(K_LOOKUP, 32'd7, 8'd0);
        queue_req(K_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        queue_req(K_INSERT, 32'hAAAA_AAAA, 8'hAA);
        queue_req(K_INSERT, 32'h5555_5555, 8'h55);
        queue_req(K_INSERT, 32'd4, 8'd1);
        queue_req(K_LOOKUP, 32'h5555_5555, 8'd0);
        queue_req(K_REMOVE, 32'hFFFF_FFFF, 8'd0);
        queue_req(K_LOOKUP, 32'hFFFF_FFFF, 8'd0);
        queue_req(K_REMOVE, 32'd4, 8'd0);
        queue_req(K_REMOVE, 32'hAAAA_AAAA, 8'd0);
        queue_req(K_REMOVE, 32'h5555_5555, 8'd0);
        queue_req(K_REMOVE, 32'h1234_5678, 8'd0);
        queue_req(K_REMOVE, 32'hFFFF_FFFF, 8'd0);
        queue_req(K_REMOVE, 32'd0, 8'd0);
        queue_req(K_REMOVE, 32'd0, 8'd0);
        // random: mixed warmup, fill past pool capacity, drain with shrinks, mixed tail
        queue_random(200, 45, 30, 20);
        queue_random(1150, 92, 5, 2);
        queue_random(300, 5, 20, 74);
        queue_random(100, 35, 35, 28);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_replies.size() == 0);
        repeat (100) @(posedge aclk);
        $display("requests: %0d insert, %0d lookup, %0d remove, %0d unused kind",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("lookups found %0d, pool-full refusals %0d, largest table %0d buckets",
                 found_seen, full_seen, peak_buckets);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
